// ===== design/epd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_pkg: shared types and constants
// Field widths, register codes and the serial multiplier control types.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int ENC_W    = 12;   // encoder reading
  localparam int WORD_W   = 16;   // rpm, duty, registers
  localparam int GAIN_W   = 16;   // multiplier operand, one bit a cycle
  localparam int STEP_W   = $clog2(GAIN_W);
  localparam int DIFF_W   = 18;   // wrapped count difference
  localparam int ACC_W    = 50;   // PID sum of products, Q42.8
  localparam int CFG_A_W  = 8;

  localparam logic [CFG_A_W-1:0] REG_RPM_PER_COUNT = 8'd0;
  localparam logic [CFG_A_W-1:0] REG_GAIN_P        = 8'd1;
  localparam logic [CFG_A_W-1:0] REG_GAIN_I        = 8'd2;
  localparam logic [CFG_A_W-1:0] REG_GAIN_D        = 8'd3;
  localparam logic [CFG_A_W-1:0] REG_PWM_MAX       = 8'd4;

  typedef struct packed {
    logic load;    // take new operands
    logic clear;   // zero the accumulator on load
  } smul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;    // one-cycle pulse after the last step
  } smul_sts_t;

endpackage

// ===== design/epd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_if: channel interfaces
// Sample, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface epd_in_if;
  import epd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ENC_W-1:0]         encoder_count;
  logic signed [WORD_W-1:0] target_rpm;
  logic [WORD_W-1:0]        duty_in;

  modport source (output valid, encoder_count, target_rpm, duty_in, input ready);
  modport sink   (input valid, encoder_count, target_rpm, duty_in, output ready);
endinterface

interface epd_out_if;
  import epd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [WORD_W-1:0]        duty_out;
  logic signed [WORD_W-1:0] measured_rpm;

  modport source (output valid, duty_out, measured_rpm, input ready);
  modport sink   (input valid, duty_out, measured_rpm, output ready);
endinterface

interface epd_cfg_if;
  import epd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] addr;
  logic [WORD_W-1:0]  wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== design/epd_wrap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_wrap: encoder count reduction and difference wrap
// Reduces the reading modulo ENCODER_TOP+1 by repeated subtraction, then
// gives the count difference folded into +/- half a revolution.
// ----------------------------------------------------------------------------
module epd_wrap #(
  parameter int ENCODER_TOP = 4095
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [epd_pkg::ENC_W-1:0]        count_in,
  input  logic [epd_pkg::ENC_W-1:0]        last_count,
  output logic                             done,
  output logic [epd_pkg::ENC_W-1:0]        count_out,
  output logic signed [epd_pkg::DIFF_W-1:0] diff
);
  import epd_pkg::*;

  localparam int MODULUS = ENCODER_TOP + 1;
  localparam logic signed [DIFF_W-1:0] MOD_S  = DIFF_W'(MODULUS);
  localparam logic signed [DIFF_W-1:0] HALF_S = DIFF_W'(ENCODER_TOP / 2);

  logic             busy;
  logic [ENC_W-1:0] x;
  logic             reduce;
  logic signed [DIFF_W-1:0] d0;

  assign reduce = int'(x) >= MODULUS;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && !reduce) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one subtraction of the modulus a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x <= count_in;
    end else if (busy && reduce) begin
      x <= x - ENC_W'(MODULUS);
    end
  end

  assign count_out = x;

  always_comb begin
    d0 = $signed({{(DIFF_W-ENC_W){1'b0}}, x}) -
         $signed({{(DIFF_W-ENC_W){1'b0}}, last_count});
    if (d0 > HALF_S)       diff = d0 - MOD_S;
    else if (d0 < -HALF_S) diff = d0 + MOD_S;
    else                   diff = d0;
  end

endmodule

// ===== design/epd_smul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_smul: bit-serial multiply-accumulate
// Signed multiplicand times unsigned 16-bit multiplier, one multiplier bit
// per cycle, added into a wide accumulator that may carry over loads.
// ----------------------------------------------------------------------------
module epd_smul (
  input  logic                              clk,
  input  logic                              rst,
  input  epd_pkg::smul_ctl_t                ctl,
  input  logic signed [epd_pkg::ACC_W-1:0]  mcand,
  input  logic [epd_pkg::GAIN_W-1:0]        mplier,
  output epd_pkg::smul_sts_t                sts,
  output logic signed [epd_pkg::ACC_W-1:0]  acc
);
  import epd_pkg::*;

  logic signed [ACC_W-1:0] mc;
  logic [GAIN_W-1:0]       mp;
  logic [STEP_W-1:0]       step;

  always_ff @(posedge clk) begin
    if (rst) begin
      sts.busy <= 1'b0;
      sts.done <= 1'b0;
      step     <= '0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.load) begin
        sts.busy <= 1'b1;
        step     <= '0;
      end else if (sts.busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(GAIN_W - 1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mc <= mcand;
      mp <= mplier;
      if (ctl.clear) acc <= '0;
    end else if (sts.busy) begin
      if (mp[0]) acc <= acc + mc;
      mc <= mc <<< 1;
      mp <= mp >> 1;
    end
  end

endmodule

// ===== design/encoder_speed_pid_duty_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_pid_duty_core: encoder speed measurement and PID duty update
// Per control tick: wrapped encoder difference -> negated rpm, speed error,
// saturating error sum, Q8.8 PID correction subtracted from the duty.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat contents                              handshake
//  -------  ---  -----------------------------------------  -----------
//  cfg      in   addr (register 0..4), wdata (16 bits)      valid/ready
//  sample   in   encoder_count, target_rpm, duty_in         valid/ready
//  result   out  duty_out, measured_rpm                     valid/ready
//
//  Sequence: one sample beat at a time. The wrap unit subtracts the modulus
//  k times (k = reading div (ENCODER_TOP+1), zero at the default top),
//  then up to four multiplier passes of 16 steps each, each followed by a
//  done pulse and hand-back. The first sample after reset skips the speed
//  pass.
//  Reset (rst, synchronous) restores register defaults and clears the
//  previous reading, error and error sum.
//  Stalls: a finished result sits in the output register; the next sample
//  is taken meanwhile and its result waits until the register drains.
//  cfg is always ready; writes are expected only while idle.
//
module encoder_speed_pid_duty_core #(
  parameter int ENCODER_TOP = 4095
) (
  input  logic       clk,
  input  logic       rst,
  epd_cfg_if.sink    cfg,
  epd_in_if.sink     sample,
  epd_out_if.source  result
);
  import epd_pkg::*;

  localparam int CORR_W = ACC_W - 8;   // after Q8.8 rounding
  localparam int DD_W   = CORR_W + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_WRAP = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_NEXT = 8'b0000_1000,
    S_ERR  = 8'b0001_0000,
    S_SUM  = 8'b0010_0000,
    S_DUTY = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  // which product the multiplier is working on
  typedef enum logic [1:0] {
    OP_SPEED = 2'd0,
    OP_P     = 2'd1,
    OP_I     = 2'd2,
    OP_D     = 2'd3
  } op_t;

  state_t state;
  op_t    op;

  // configuration registers
  logic [WORD_W-1:0] rpm_per_count, gain_p, gain_i, gain_d, pwm_max;

  // loop state
  logic [ENC_W-1:0]         last_count;
  logic                     first_sample;
  logic signed [DIFF_W-1:0] last_error;
  logic signed [31:0]       error_sum;

  // per-sample working registers
  logic signed [WORD_W-1:0] target;
  logic [WORD_W-1:0]        duty;
  logic signed [WORD_W-1:0] rpm;
  logic signed [DIFF_W-1:0] err;
  logic signed [31:0]       sum;

  // result registers waiting for the output
  logic [WORD_W-1:0]        res_duty;

  // sub-units
  logic                     wrap_start, wrap_done;
  logic [ENC_W-1:0]         wrap_count;
  logic signed [DIFF_W-1:0] wrap_diff;
  smul_ctl_t                mul_ctl;
  smul_sts_t                mul_sts;
  logic signed [ACC_W-1:0]  mul_mcand, mul_acc;
  logic [GAIN_W-1:0]        mul_mplier;

  // combinational datapath
  logic signed [CORR_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0]  acc_bias;
  logic signed [DIFF_W-1:0] err_next;
  logic signed [32:0]       sum_wide;
  logic signed [31:0]       sum_next;
  logic signed [DIFF_W:0]   derr;
  logic signed [DD_W-1:0]   duty_wide;
  logic [WORD_W-1:0]        duty_next;
  logic signed [WORD_W-1:0] rpm_next;

  epd_wrap #(
    .ENCODER_TOP (ENCODER_TOP)
  ) u_wrap (
    .clk        (clk),
    .rst        (rst),
    .start      (wrap_start),
    .count_in   (sample.encoder_count),
    .last_count (last_count),
    .done       (wrap_done),
    .count_out  (wrap_count),
    .diff       (wrap_diff)
  );

  epd_smul u_smul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mul_ctl),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .sts    (mul_sts),
    .acc    (mul_acc)
  );

  // --- handshakes --------------------------------------------------------
  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_IDLE);
  assign wrap_start   = sample.valid && sample.ready;

  // --- rounding: floor((x + 128) / 256) is an arithmetic shift ----------
  assign acc_bias = mul_acc + ACC_W'(128);
  assign acc_rnd  = acc_bias[ACC_W-1:8];

  always_comb begin
    if (acc_rnd > $signed(CORR_W'(32767)))       rpm_next = 16'sh7fff;
    else if (acc_rnd < -$signed(CORR_W'(32768))) rpm_next = 16'sh8000;
    else                                          rpm_next = acc_rnd[WORD_W-1:0];
  end

  // speed error: sign of the comparison follows the sign of the speed
  always_comb begin
    if (rpm > 0)
      err_next = {{2{rpm[WORD_W-1]}}, rpm} - {{2{target[WORD_W-1]}}, target};
    else
      err_next = {{2{target[WORD_W-1]}}, target} - {{2{rpm[WORD_W-1]}}, rpm};
  end

  // saturating integrator
  always_comb begin
    sum_wide = {{(33-DIFF_W){err[DIFF_W-1]}}, err} + {error_sum[31], error_sum};
    if (sum_wide[32] != sum_wide[31])
      sum_next = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else
      sum_next = sum_wide[31:0];
  end

  assign derr = {err[DIFF_W-1], err} - {last_error[DIFF_W-1], last_error};

  // duty minus correction, clamped to 0..pwm_max
  always_comb begin
    duty_wide = $signed({{(DD_W-WORD_W){1'b0}}, duty}) - {acc_rnd[CORR_W-1], acc_rnd};
    if (duty_wide < 0)                            duty_next = '0;
    else if (duty_wide > $signed(DD_W'(pwm_max))) duty_next = pwm_max;
    else                                          duty_next = duty_wide[WORD_W-1:0];
  end

  // --- multiplier operand selection --------------------------------------
  always_comb begin
    mul_ctl    = '0;
    mul_mcand  = '0;
    mul_mplier = '0;
    unique case (state)
      S_WRAP: begin
        if (wrap_done && !first_sample) begin
          // negated speed: multiply the negated difference
          mul_ctl.load  = 1'b1;
          mul_ctl.clear = 1'b1;
          mul_mcand     = -{{(ACC_W-DIFF_W){wrap_diff[DIFF_W-1]}}, wrap_diff};
          mul_mplier    = rpm_per_count;
        end
      end
      S_SUM: begin
        mul_ctl.load  = 1'b1;
        mul_ctl.clear = 1'b1;
        mul_mcand     = {{(ACC_W-DIFF_W){err[DIFF_W-1]}}, err};
        mul_mplier    = gain_p;
      end
      S_NEXT: begin
        case (op)
          OP_P: begin
            mul_ctl.load = 1'b1;
            mul_mcand    = {{(ACC_W-32){sum[31]}}, sum};
            mul_mplier   = gain_i;
          end
          OP_I: begin
            mul_ctl.load = 1'b1;
            mul_mcand    = {{(ACC_W-DIFF_W-1){derr[DIFF_W]}}, derr};
            mul_mplier   = gain_d;
          end
          default: ;
        endcase
      end
      S_IDLE, S_MUL, S_ERR, S_DUTY, S_OUT: ;
      default: ;
    endcase
  end

  // --- sequencer ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_SPEED;
      last_count   <= '0;
      first_sample <= 1'b1;
      last_error   <= '0;
      error_sum    <= '0;
      result.valid <= 1'b0;
    end else begin
      // output register: loads from S_OUT when free, empties on a taken beat
      if (state == S_OUT && (!result.valid || result.ready)) result.valid <= 1'b1;
      else if (result.ready)                                  result.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (sample.valid) state <= S_WRAP;
        end
        S_WRAP: begin
          if (wrap_done) begin
            last_count   <= wrap_count;
            first_sample <= 1'b0;
            op           <= OP_SPEED;
            state        <= first_sample ? S_ERR : S_MUL;
          end
        end
        S_MUL: begin
          if (mul_sts.done) state <= S_NEXT;
        end
        S_NEXT: begin
          case (op)
            OP_SPEED: state <= S_ERR;
            OP_P:     begin op <= OP_I; state <= S_MUL; end
            OP_I:     begin op <= OP_D; state <= S_MUL; end
            OP_D:     state <= S_DUTY;
            default:  state <= S_DUTY;
          endcase
        end
        S_ERR: state <= S_SUM;
        S_SUM: begin
          op    <= OP_P;
          state <= S_MUL;
        end
        S_DUTY: begin
          last_error <= err;
          error_sum  <= sum;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!result.valid || result.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --- payload registers ------------------------------------------------
  always_ff @(posedge clk) begin
    if (wrap_start) begin
      target <= sample.target_rpm;
      duty   <= sample.duty_in;
    end
    if (state == S_WRAP && wrap_done && first_sample) rpm <= '0;
    if (state == S_NEXT && op == OP_SPEED)              rpm <= rpm_next;
    if (state == S_ERR)  err      <= err_next;
    if (state == S_SUM)  sum      <= sum_next;
    if (state == S_DUTY) res_duty <= duty_next;
    if (state == S_OUT && (!result.valid || result.ready)) begin
      result.duty_out     <= res_duty;
      result.measured_rpm <= rpm;
    end
  end

  // --- configuration registers ------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_per_count <= 16'd3750;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      pwm_max       <= 16'd1000;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.addr)
        REG_RPM_PER_COUNT: rpm_per_count <= cfg.wdata;
        REG_GAIN_P:        gain_p        <= cfg.wdata;
        REG_GAIN_I:        gain_i        <= cfg.wdata;
        REG_GAIN_D:        gain_d        <= cfg.wdata;
        REG_PWM_MAX:       pwm_max       <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // --- assertions ---------------------------------------------------------
  // multiplier is never reloaded mid-pass
  a_mul_no_overrun: assert property (@(posedge clk) disable iff (rst)
    mul_ctl.load |-> !mul_sts.busy)
    else $error("multiplier loaded while busy");

  // a pass only finishes while the sequencer waits for it
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_sts.done |-> state == S_MUL)
    else $error("multiplier finished outside S_MUL");

  // a new result only appears from the output state
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_OUT))
    else $error("result raised outside S_OUT");

  // the wrap unit only reports back while it is awaited
  a_wrap_done_state: assert property (@(posedge clk) disable iff (rst)
    wrap_done |-> state == S_WRAP)
    else $error("wrap unit finished outside S_WRAP");

endmodule
